// ===== rtl/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// Shared widths, operation codes and controller/datapath handshake structs
// for the positional array list.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

  // field widths of the channel payloads
  localparam int unsigned OP_W   = 2;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned FIDX_W = 9;
  localparam int unsigned LEN_W  = 10;

  // default list capacity
  localparam int unsigned MAX_LEN_DEF = 512;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_GET    = 2'd2;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // latch the incoming item
    logic rd_pos;     // read the entry at the requested position
    logic cap_rd;     // capture the read entry as the result word
    logic scan_init;  // set up the read pointer and remaining count
    logic step;       // scan step: read next, write or compare previous
    logic finish;     // close an insert or delete, update the length
    logic found;      // record a find hit
    logic emit;       // move the result into the output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic            refuse;    // request is out of range, or an insert into a full list
    logic            busy;      // reads left or a read still in flight
    logic            hit;       // entry in flight matches the search value
    logic            out_busy;  // output register holds an untaken result
    logic [OP_W-1:0] op;        // latched operation
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/pal_if.sv =====
// ----------------------------------------------------------------------------
// pal_if
// Valid/ready channel interfaces for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface pal_in_if;
  import pal_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [POS_W-1:0]         position;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface pal_out_if;
  import pal_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [VAL_W-1:0]  read_value;
  logic [FIDX_W-1:0]        found_index;
  logic [LEN_W-1:0]         list_length;

  modport source (output valid, output ok, output read_value, output found_index,
                  output list_length, input ready);
  modport sink   (input valid, input ok, input read_value, input found_index,
                  input list_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/pal_ram.sv =====
// ----------------------------------------------------------------------------
// pal_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/pal_dp.sv =====
// ----------------------------------------------------------------------------
// pal_dp
// Datapath: entry store, length register, scan pointer, result and output
// registers. Shifts run one entry a cycle with the read and write overlapped.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_dp #(
  parameter int unsigned MAX_LEN = pal_pkg::MAX_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pal_pkg::cmd_t                   cmd,
  output pal_pkg::sts_t                   sts,
  input  logic [pal_pkg::OP_W-1:0]        in_op,
  input  logic [pal_pkg::POS_W-1:0]       in_position,
  input  logic signed [pal_pkg::VAL_W-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_ok,
  output logic signed [pal_pkg::VAL_W-1:0] out_read_value,
  output logic [pal_pkg::FIDX_W-1:0]      out_found_index,
  output logic [pal_pkg::LEN_W-1:0]       out_list_length
);
  import pal_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned IDX_W = $clog2(MAX_LEN);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);
  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(MAX_LEN);

  // latched request
  logic [OP_W-1:0]  op_r;
  logic [CMP_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;

  // list state and scan control
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] pend_addr_r, pend_addr_nxt;

  // working result
  logic             ok_r, ok_nxt;
  logic [VAL_W-1:0] rdv_r, rdv_nxt;
  logic [CNT_W-1:0] fidx_r, fidx_nxt;

  // output register
  logic              out_valid_r;
  logic              out_ok_r;
  logic [VAL_W-1:0]  out_rdv_r;
  logic [FIDX_W-1:0] out_fidx_r;
  logic [LEN_W-1:0]  out_len_r;

  // memory ports
  logic             mem_we;
  logic [CNT_W-1:0] mem_waddr_full;
  logic [IDX_W-1:0] mem_raddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [VAL_W-1:0] mem_rdata;

  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] fidx_ext;
  logic             is_ins;
  logic             is_shift_op;
  logic             refuse;

  assign count_ext   = CMP_W'(count_r);
  assign fidx_ext    = CMP_W'(fidx_r);
  assign is_ins      = (op_r == OP_INSERT);
  assign is_shift_op = (op_r == OP_INSERT) || (op_r == OP_DELETE);

  // range checks against the current length
  always_comb begin
    case (op_r)
      OP_INSERT: refuse = (pos_r > count_ext) || (count_r == FULL_C);
      OP_DELETE: refuse = (pos_r >= count_ext);
      OP_GET:    refuse = (pos_r >= count_ext);
      OP_FIND:   refuse = 1'b0;
      default:   refuse = 1'b0;
    endcase
  end

  assign sts.refuse   = refuse;
  assign sts.busy     = (rem_r != '0) || pend_r;
  assign sts.hit      = pend_r && (mem_rdata == val_r);
  assign sts.out_busy = out_valid_r && !out_ready;
  assign sts.op       = op_r;

  // entry store
  pal_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_LEN)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr_full[IDX_W-1:0]),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // read address: the requested position or the scan pointer
  assign mem_raddr = cmd.rd_pos ? pos_r[IDX_W-1:0] : rp_r[IDX_W-1:0];

  // write: shifted entry one place up or down, or the new value on insert
  always_comb begin
    mem_we         = 1'b0;
    mem_wdata      = mem_rdata;
    mem_waddr_full = is_ins ? (pend_addr_r + ONE_C) : (pend_addr_r - ONE_C);
    if (cmd.finish && is_ins) begin
      mem_we         = 1'b1;
      mem_wdata      = val_r;
      mem_waddr_full = CNT_W'(pos_r);
    end else if (cmd.step && pend_r && is_shift_op) begin
      mem_we = 1'b1;
    end
  end

  // scan pointer, remaining reads and length
  always_comb begin
    count_nxt     = count_r;
    rp_nxt        = rp_r;
    rem_nxt       = rem_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    ok_nxt        = ok_r;
    rdv_nxt       = rdv_r;
    fidx_nxt      = fidx_r;
    if (cmd.load) begin
      ok_nxt   = 1'b0;
      rdv_nxt  = '0;
      fidx_nxt = '0;
    end
    if (cmd.cap_rd) begin
      ok_nxt  = 1'b1;
      rdv_nxt = mem_rdata;
    end
    if (cmd.scan_init) begin
      case (op_r)
        OP_INSERT: begin
          rp_nxt  = count_r - ONE_C;
          rem_nxt = CNT_W'(count_ext - pos_r);
        end
        OP_DELETE: begin
          rp_nxt  = CNT_W'(pos_r) + ONE_C;
          rem_nxt = CNT_W'(count_ext - pos_r) - ONE_C;
        end
        default: begin
          rp_nxt  = '0;
          rem_nxt = count_r;
        end
      endcase
    end
    if (cmd.step && (rem_r != '0)) begin
      rp_nxt        = is_ins ? (rp_r - ONE_C) : (rp_r + ONE_C);
      rem_nxt       = rem_r - ONE_C;
      pend_nxt      = 1'b1;
      pend_addr_nxt = rp_r;
    end
    if (cmd.finish) begin
      ok_nxt    = 1'b1;
      count_nxt = is_ins ? (count_r + ONE_C) : (count_r - ONE_C);
    end
    if (cmd.found) begin
      ok_nxt   = 1'b1;
      fidx_nxt = pend_addr_r;
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      pos_r <= CMP_W'(in_position);
      val_r <= in_value;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
      rem_r   <= '0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rp_r        <= rp_nxt;
    pend_addr_r <= pend_addr_nxt;
    ok_r        <= ok_nxt;
    rdv_r       <= rdv_nxt;
    fidx_r      <= fidx_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ok_r   <= ok_r;
      out_rdv_r  <= rdv_r;
      out_fidx_r <= fidx_ext[FIDX_W-1:0];
      out_len_r  <= count_ext[LEN_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_read_value  = out_rdv_r;
  assign out_found_index = out_fidx_r;
  assign out_list_length = out_len_r;

endmodule

`default_nettype wire

// ===== rtl/pal_ctrl.sv =====
// ----------------------------------------------------------------------------
// pal_ctrl
// Controller: takes one item at a time, sequences the position read, the
// shift or search scan, and the hand-over to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pal_pkg::sts_t sts,
  output pal_pkg::cmd_t cmd
);
  import pal_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.refuse) begin
          state_nxt = S_RESP;
        end else begin
          case (sts.op)
            OP_INSERT: begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SHIFT;
            end
            OP_FIND: begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end
            default: begin
              cmd.rd_pos = 1'b1;
              state_nxt  = S_RDWAIT;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        cmd.cap_rd = 1'b1;
        if (sts.op == OP_DELETE) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SHIFT;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_SHIFT: begin
        if (sts.busy) begin
          cmd.step = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_RESP;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.found = 1'b1;
          state_nxt = S_RESP;
        end else if (sts.busy) begin
          cmd.step = 1'b1;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/positional_array_list.sv =====
// ----------------------------------------------------------------------------
// positional_array_list
// Bounded ordered list of signed 32-bit words with insert, delete, get and
// find requests; one result item per request item.
// ----------------------------------------------------------------------------
// Usage
//   in_if  : request items (op, position, value), valid/ready.
//   out_if : one result item per request (ok, read_value, found_index,
//            list_length), valid/ready.
//   One request is worked on at a time; in_if.ready is high only while the
//   block waits for a new item. The entry store has one read and one write
//   port, and moved or searched entries pass through it one at a time. A
//   refused request goes straight to the result; a get reads the position;
//   an insert shifts the entries from p up by one, then writes the value; a
//   delete reads the position, then shifts the entries above it down; a find
//   scans from index 0 and stops at the first hit or at the end of the list.
//   Results sit in an output register; a new request is taken while a result
//   waits, and the next result is held back until the receiver takes the
//   waiting one.
//   Reset empties the list (length 0) at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list #(
  parameter int unsigned MAX_LEN = pal_pkg::MAX_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pal_in_if.sink    in_if,
  pal_out_if.source out_if
);
  import pal_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  pal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, scan and result registers
  pal_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_if.op),
    .in_position     (in_if.position),
    .in_value        (in_if.value),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_ok          (out_if.ok),
    .out_read_value  (out_if.read_value),
    .out_found_index (out_if.found_index),
    .out_list_length (out_if.list_length)
  );

  // one item at a time: no second accept straight after the first
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("request taken while another is in progress");

  // a non-zero index only comes with a successful find
  a_index_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.found_index != '0)) |-> out_if.ok)
    else $error("found index set on a failed result");

  // refused or absent results carry no word
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.ok) |-> (out_if.read_value == '0))
    else $error("read value set on a failed result");

  // a step command is never issued without reads or a read in flight
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> sts.busy)
    else $error("scan step with nothing to do");

endmodule

`default_nettype wire
